[rtl/mcw_pkg.sv]
// Shared types, codes and index helpers for the Morton-order cube walker.
package mcw_pkg;

  localparam int CoordBits = 4;
  localparam int ZBits     = 3 * CoordBits;
  localparam int WordBits  = 32;
  localparam int SideBits  = 5;
  localparam int MaxSide   = 16;
  localparam int Depth     = MaxSide * MaxSide * MaxSide;

  // Action codes
  localparam logic [2:0] ACT_TELEPORT = 3'd0;
  localparam logic [2:0] ACT_WRITE    = 3'd1;
  localparam logic [2:0] ACT_K_DOWN   = 3'd2;
  localparam logic [2:0] ACT_K_UP     = 3'd3;
  localparam logic [2:0] ACT_J_DOWN   = 3'd4;
  localparam logic [2:0] ACT_J_UP     = 3'd5;
  localparam logic [2:0] ACT_I_DOWN   = 3'd6;
  localparam logic [2:0] ACT_I_UP     = 3'd7;

  // Status codes
  localparam logic [1:0] ST_DONE    = 2'd0;
  localparam logic [1:0] ST_BLOCKED = 2'd1;
  localparam logic [1:0] ST_RANGE   = 2'd2;

  // Index bits that belong to each axis
  localparam logic [ZBits-1:0] MaskK = 12'h249;
  localparam logic [ZBits-1:0] MaskJ = 12'h492;
  localparam logic [ZBits-1:0] MaskI = 12'h924;

  typedef struct packed {
    logic [2:0]                 action;
    logic [CoordBits-1:0]       coord_i;
    logic [CoordBits-1:0]       coord_j;
    logic [CoordBits-1:0]       coord_k;
    logic signed [WordBits-1:0] write_value;
  } in_t;

  typedef struct packed {
    logic signed [WordBits-1:0] cell_value;
    logic [ZBits-1:0]           z_index;
    logic [CoordBits-1:0]       pos_i;
    logic [CoordBits-1:0]       pos_j;
    logic [CoordBits-1:0]       pos_k;
    logic [1:0]                 status;
  } out_t;

  typedef struct packed {
    logic [CoordBits-1:0] i;
    logic [CoordBits-1:0] j;
    logic [CoordBits-1:0] k;
    logic [ZBits-1:0]     z;
  } cursor_t;

  // Decision of the step logic for one transaction
  typedef struct packed {
    cursor_t          cursor;
    logic [1:0]       status;
    logic             fetch;
    logic             write;
    logic [ZBits-1:0] waddr;
  } step_t;

  // Interleave: bit 3b+2 from i, 3b+1 from j, 3b from k
  function automatic logic [ZBits-1:0] morton(input logic [CoordBits-1:0] i,
                                              input logic [CoordBits-1:0] j,
                                              input logic [CoordBits-1:0] k);
    logic [ZBits-1:0] z;
    z = '0;
    for (int b = 0; b < CoordBits; b++) begin
      z[3*b]     = k[b];
      z[3*b + 1] = j[b];
      z[3*b + 2] = i[b];
    end
    return z;
  endfunction

endpackage

[rtl/morton_order_cube_walker_core.sv]
// Top level of the Morton-order cube walker: cursor, cell memory, output register.
//
// The cube is held in a 4096 x 32 single-port-style memory addressed by the
// Morton index of (i, j, k). One transaction is taken per clock: the cursor
// registers update at the accepting edge, a write goes to memory on that same
// edge, and a teleport or move issues its memory read there. The decision and
// the registered read data pass through the read stage into an output register,
// where the result sits until taken. The intake stalls only while a finished
// result is held and the one behind it cannot move on. Side length is written
// through the config channel, which is always ready.
module morton_order_cube_walker_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [mcw_pkg::SideBits-1:0]  cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  mcw_pkg::in_t                  in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output mcw_pkg::out_t                 out_data
);

  logic [mcw_pkg::SideBits-1:0]  side;
  mcw_pkg::cursor_t              cursor;
  mcw_pkg::step_t                step;
  logic                          accept;
  logic                          advance;

  // Read stage
  logic                          p1_valid;
  mcw_pkg::cursor_t              p1_cursor;
  logic [1:0]                    p1_status;
  logic                          p1_fetch;

  logic [mcw_pkg::WordBits-1:0]  mem [mcw_pkg::Depth];
  logic [mcw_pkg::WordBits-1:0]  rdata;
  logic [mcw_pkg::WordBits-1:0]  cached_word;
  logic [mcw_pkg::WordBits-1:0]  word_next;

  assign cfg_ready = 1'b1;
  assign advance   = !out_valid || out_ready;
  assign in_ready  = !p1_valid || advance;
  assign accept    = in_valid && in_ready;

  mcw_step u_step (
    .cursor (cursor),
    .item   (in_data),
    .side   (side),
    .step   (step)
  );

  // Side length register
  always_ff @(posedge clk) begin
    if (rst) begin
      side <= mcw_pkg::SideBits'(mcw_pkg::MaxSide);
    end else if (cfg_valid) begin
      side <= cfg_data;
    end
  end

  // Cursor registers move at the accepting edge
  always_ff @(posedge clk) begin
    if (rst) begin
      cursor <= '0;
    end else if (accept) begin
      cursor <= step.cursor;
    end
  end

  // Cell memory: write on a write transaction, read on a fetch
  always_ff @(posedge clk) begin
    if (accept && step.write) begin
      mem[step.waddr] <= in_data.write_value;
    end
    if (accept && step.fetch) begin
      rdata <= mem[step.cursor.z];
    end
  end

  // Read stage tracking
  always_ff @(posedge clk) begin
    if (rst) begin
      p1_valid <= 1'b0;
    end else if (accept) begin
      p1_valid <= 1'b1;
    end else if (advance) begin
      p1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      p1_cursor <= step.cursor;
      p1_status <= step.status;
      p1_fetch  <= step.fetch;
    end
  end

  assign word_next = p1_fetch ? rdata : cached_word;

  // Cached word follows the fetched data
  always_ff @(posedge clk) begin
    if (rst) begin
      cached_word <= '0;
    end else if (p1_valid && advance) begin
      cached_word <= word_next;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= p1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (p1_valid && advance) begin
      out_data.cell_value <= word_next;
      out_data.z_index    <= p1_cursor.z;
      out_data.pos_i      <= p1_cursor.i;
      out_data.pos_j      <= p1_cursor.j;
      out_data.pos_k      <= p1_cursor.k;
      out_data.status     <= p1_status;
    end
  end

endmodule

[rtl/mcw_step.sv]
// Cursor step logic: teleport, write address and masked index moves.
module mcw_step (
  input  mcw_pkg::cursor_t             cursor,
  input  mcw_pkg::in_t                 item,
  input  logic [mcw_pkg::SideBits-1:0] side,
  output mcw_pkg::step_t               step
);

  logic [mcw_pkg::SideBits-1:0]  side_use;
  logic [mcw_pkg::CoordBits-1:0] pos;
  logic [mcw_pkg::ZBits-1:0]     mask;
  logic [mcw_pkg::ZBits-1:0]     z_up;
  logic [mcw_pkg::ZBits-1:0]     z_dn;
  logic [mcw_pkg::CoordBits-1:0] pos_new;
  logic                          up;
  logic                          blocked;
  logic                          out_of_range;

  // Edge length clamped to 1..MaxSide
  always_comb begin
    if (side == '0) begin
      side_use = mcw_pkg::SideBits'(1);
    end else if (side > mcw_pkg::SideBits'(mcw_pkg::MaxSide)) begin
      side_use = mcw_pkg::SideBits'(mcw_pkg::MaxSide);
    end else begin
      side_use = side;
    end
  end

  // Axis selection for moves
  always_comb begin
    unique case (item.action[2:1])
      2'b11: begin
        pos  = cursor.i;
        mask = mcw_pkg::MaskI;
      end
      2'b10: begin
        pos  = cursor.j;
        mask = mcw_pkg::MaskJ;
      end
      default: begin
        pos  = cursor.k;
        mask = mcw_pkg::MaskK;
      end
    endcase
  end

  assign up      = item.action[0];
  assign blocked = up ? ({1'b0, pos} >= side_use - mcw_pkg::SideBits'(1)) : (pos == '0);
  assign pos_new = up ? pos + mcw_pkg::CoordBits'(1) : pos - mcw_pkg::CoordBits'(1);

  // Masked add / subtract on the interleaved index
  assign z_up = (((cursor.z | ~mask) + mcw_pkg::ZBits'(1)) & mask) | (cursor.z & ~mask);
  assign z_dn = (((cursor.z & mask) - mcw_pkg::ZBits'(1)) & mask) | (cursor.z & ~mask);

  assign out_of_range = ({1'b0, item.coord_i} >= side_use) ||
                        ({1'b0, item.coord_j} >= side_use) ||
                        ({1'b0, item.coord_k} >= side_use);

  // Action decode
  always_comb begin
    step.cursor = cursor;
    step.status = mcw_pkg::ST_DONE;
    step.fetch  = 1'b0;
    step.write  = 1'b0;
    step.waddr  = mcw_pkg::morton(item.coord_i, item.coord_j, item.coord_k);
    unique case (item.action)
      mcw_pkg::ACT_TELEPORT: begin
        if (out_of_range) begin
          step.status = mcw_pkg::ST_RANGE;
        end else begin
          step.cursor.i = item.coord_i;
          step.cursor.j = item.coord_j;
          step.cursor.k = item.coord_k;
          step.cursor.z = step.waddr;
          step.fetch    = 1'b1;
        end
      end
      mcw_pkg::ACT_WRITE: begin
        step.write = 1'b1;
      end
      default: begin
        if (blocked) begin
          step.status = mcw_pkg::ST_BLOCKED;
        end else begin
          step.fetch    = 1'b1;
          step.cursor.z = up ? z_up : z_dn;
          unique case (item.action) inside
            mcw_pkg::ACT_I_DOWN, mcw_pkg::ACT_I_UP: step.cursor.i = pos_new;
            mcw_pkg::ACT_J_DOWN, mcw_pkg::ACT_J_UP: step.cursor.j = pos_new;
            default:                                step.cursor.k = pos_new;
          endcase
        end
      end
    endcase
  end

endmodule

[bench/testbench.sv]
// Self-checking bench for the Morton-order cube walker: random walks, writes and side changes.
module testbench;
  import mcw_pkg::*;

  localparam int               CUBE_EDGE  = 16;
  localparam int               QUIET_MAX  = 1000;
  localparam int               WALK_ITEMS = 166;
  localparam logic [ZBits-1:0] LANES_K    = 12'h249;
  localparam logic [ZBits-1:0] LANES_J    = 12'h492;
  localparam logic [ZBits-1:0] LANES_I    = 12'h924;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [SideBits-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_t  in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;

  morton_order_cube_walker_core dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Actions waiting to be driven, and cursor reports waiting to come back
  in_t  action_queue[$];
  out_t cursor_reports[$];

  // Predictor state: cube contents, cursor and side register
  logic [WordBits-1:0]  cube_cells [Depth];
  logic [CoordBits-1:0] cur_i = '0, cur_j = '0, cur_k = '0;
  logic [ZBits-1:0]     cur_z = '0;
  logic [WordBits-1:0]  held_word = '0;
  logic [SideBits-1:0]  side_reg = 5'd16;

  // Planning state for stimulus: where the cursor will be, which cells hold data
  bit                   filled [Depth];
  logic [CoordBits-1:0] plan_i = '0, plan_j = '0, plan_k = '0;
  int                   plan_side = CUBE_EDGE;

  int   errors = 0;
  int   actions_sent = 0;
  int   reports_seen = 0;
  int   side_writes = 0;
  int   n_done = 0, n_blocked = 0, n_range = 0;
  int   quiet = 0;
  bit   in_took = 1'b0;
  bit   in_calm = 1'b0, out_calm = 1'b0;
  int   in_gap = 0, out_hold = 0;
  out_t want;

  // Spread four bits to every third position of the index
  function automatic logic [ZBits-1:0] spread3(input logic [CoordBits-1:0] v);
    logic [ZBits-1:0] w;
    w = {8'b0, v};
    w = (w ^ (w << 4)) & 12'h0C3;
    w = (w ^ (w << 2)) & 12'h249;
    return w;
  endfunction

  function automatic logic [ZBits-1:0] zip3(input logic [CoordBits-1:0] i,
                                            input logic [CoordBits-1:0] j,
                                            input logic [CoordBits-1:0] k);
    return spread3(k) | (spread3(j) << 1) | (spread3(i) << 2);
  endfunction

  // Zero acts as one, anything above the cube edge saturates
  function automatic int side_in_force(input logic [SideBits-1:0] s);
    if (s == 0) return 1;
    if (s > CUBE_EDGE) return CUBE_EDGE;
    return s;
  endfunction

  // Mostly no gap, some short ones, a few long; none at all while calm
  function automatic int idle_len(input bit calm);
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 70) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(6, 30);
  endfunction

  function automatic logic [WordBits-1:0] rand_word();
    case ($urandom_range(0, 9))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'h0000_0000;
      3: return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  // Predict the report for one accepted transaction
  task automatic advance_cursor(input in_t it);
    out_t                 r;
    int                   side;
    logic [1:0]           st;
    logic [ZBits-1:0]     lanes;
    logic [CoordBits-1:0] p;
    bit                   up;
    side = side_in_force(side_reg);
    st = ST_DONE;
    case (it.action)
      ACT_TELEPORT: begin
        if (it.coord_i >= side || it.coord_j >= side || it.coord_k >= side) begin
          st = ST_RANGE;
        end else begin
          cur_i = it.coord_i;
          cur_j = it.coord_j;
          cur_k = it.coord_k;
          cur_z = zip3(it.coord_i, it.coord_j, it.coord_k);
          held_word = cube_cells[cur_z];
        end
      end
      ACT_WRITE: begin
        cube_cells[zip3(it.coord_i, it.coord_j, it.coord_k)] = it.write_value;
      end
      default: begin
        up = (it.action == ACT_K_UP || it.action == ACT_J_UP || it.action == ACT_I_UP);
        if (it.action == ACT_K_DOWN || it.action == ACT_K_UP) begin
          lanes = LANES_K;
          p = cur_k;
        end else if (it.action == ACT_J_DOWN || it.action == ACT_J_UP) begin
          lanes = LANES_J;
          p = cur_j;
        end else begin
          lanes = LANES_I;
          p = cur_i;
        end
        if (up ? (p >= side - 1) : (p == 0)) begin
          st = ST_BLOCKED;
        end else begin
          p = up ? p + 4'd1 : p - 4'd1;
          if (lanes == LANES_K) cur_k = p;
          else if (lanes == LANES_J) cur_j = p;
          else cur_i = p;
          // carry or borrow runs only through this axis' lanes
          if (up) cur_z = (((cur_z | ~lanes) + 12'd1) & lanes) | (cur_z & ~lanes);
          else    cur_z = (((cur_z & lanes) - 12'd1) & lanes) | (cur_z & ~lanes);
          held_word = cube_cells[cur_z];
        end
      end
    endcase
    r.cell_value = held_word;
    r.z_index    = cur_z;
    r.pos_i      = cur_i;
    r.pos_j      = cur_j;
    r.pos_k      = cur_k;
    r.status     = st;
    cursor_reports.push_back(r);
  endtask

  task automatic field_check(input string name, input logic [31:0] exp_v,
                             input logic [31:0] got_v);
    if (exp_v !== got_v) begin
      $display("%0t: %s mismatch, expected %h got %h", $time, name, exp_v, got_v);
      errors++;
    end
  endtask

  // Queue one action; a visit to an empty cell gets a write to that cell first
  task automatic queue_item(input logic [2:0] act, input logic [CoordBits-1:0] ci,
                            input logic [CoordBits-1:0] cj, input logic [CoordBits-1:0] ck,
                            input logic [WordBits-1:0] wv);
    in_t                  it;
    logic [CoordBits-1:0] ti, tj, tk;
    bit                   reads;
    ti = plan_i;
    tj = plan_j;
    tk = plan_k;
    reads = 1'b0;
    case (act)
      ACT_TELEPORT: begin
        if (ci < plan_side && cj < plan_side && ck < plan_side) begin
          ti = ci;
          tj = cj;
          tk = ck;
          reads = 1'b1;
        end
      end
      ACT_WRITE: ;
      ACT_K_DOWN: if (tk != 0) begin tk--; reads = 1'b1; end
      ACT_K_UP:   if (tk < plan_side - 1) begin tk++; reads = 1'b1; end
      ACT_J_DOWN: if (tj != 0) begin tj--; reads = 1'b1; end
      ACT_J_UP:   if (tj < plan_side - 1) begin tj++; reads = 1'b1; end
      ACT_I_DOWN: if (ti != 0) begin ti--; reads = 1'b1; end
      ACT_I_UP:   if (ti < plan_side - 1) begin ti++; reads = 1'b1; end
      default: ;
    endcase
    if (reads && !filled[zip3(ti, tj, tk)]) begin
      it.action      = ACT_WRITE;
      it.coord_i     = ti;
      it.coord_j     = tj;
      it.coord_k     = tk;
      it.write_value = rand_word();
      action_queue.push_back(it);
      filled[zip3(ti, tj, tk)] = 1'b1;
    end
    if (act == ACT_WRITE) filled[zip3(ci, cj, ck)] = 1'b1;
    it.action      = act;
    it.coord_i     = ci;
    it.coord_j     = cj;
    it.coord_k     = ck;
    it.write_value = wv;
    action_queue.push_back(it);
    plan_i = ti;
    plan_j = tj;
    plan_k = tk;
  endtask

  // One random action: writes anywhere, teleports mostly in range, mostly moves
  task automatic random_item();
    int r;
    r = $urandom_range(0, 99);
    if (r < 22) begin
      queue_item(ACT_WRITE, CoordBits'($urandom_range(0, 15)),
                 CoordBits'($urandom_range(0, 15)),
                 CoordBits'($urandom_range(0, 15)), rand_word());
    end else if (r < 34) begin
      if ($urandom_range(0, 9) < 7)
        queue_item(ACT_TELEPORT, CoordBits'($urandom_range(0, plan_side - 1)),
                   CoordBits'($urandom_range(0, plan_side - 1)),
                   CoordBits'($urandom_range(0, plan_side - 1)),
                   $urandom);
      else
        queue_item(ACT_TELEPORT, CoordBits'($urandom_range(0, 15)),
                   CoordBits'($urandom_range(0, 15)),
                   CoordBits'($urandom_range(0, 15)), $urandom);
    end else begin
      queue_item(3'($urandom_range(ACT_K_DOWN, ACT_I_UP)),
                 CoordBits'($urandom_range(0, 15)),
                 CoordBits'($urandom_range(0, 15)),
                 CoordBits'($urandom_range(0, 15)), $urandom);
    end
  endtask

  // Wait until every queued transaction has been taken and reported
  task automatic drain();
    do @(posedge clk);
    while (action_queue.size() != 0 || in_valid || cursor_reports.size() != 0);
  endtask

  task automatic set_side(input logic [SideBits-1:0] v);
    @(negedge clk);
    cfg_data  <= v;
    cfg_valid <= 1'b1;
    plan_side = side_in_force(v);
    do @(posedge clk);
    while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Input driver: hold until taken, then next action after a random gap
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_took) begin
      in_took = 1'b0;
      if ($urandom_range(0, 99) == 0) in_calm = ~in_calm;
      if (in_gap > 0) begin
        in_gap--;
        in_valid <= 1'b0;
      end else if (action_queue.size() != 0) begin
        in_data  <= action_queue.pop_front();
        in_valid <= 1'b1;
        in_gap = idle_len(in_calm);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Output back-pressure
  always @(negedge clk) begin
    if ($urandom_range(0, 99) == 0) out_calm = ~out_calm;
    if (out_hold > 0) begin
      out_hold--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
      out_hold = idle_len(out_calm);
    end
  end

  // Monitor: register writes, accepted actions, reports
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_valid && cfg_ready) begin
        side_reg = cfg_data;
        side_writes++;
      end
      if (in_valid && in_ready) begin
        advance_cursor(in_data);
        in_took = 1'b1;
        actions_sent++;
      end
      if (out_valid && out_ready) begin
        reports_seen++;
        if (cursor_reports.size() == 0) begin
          $display("%0t: unexpected report, expected none got %h", $time, out_data);
          errors++;
        end else begin
          want = cursor_reports.pop_front();
          field_check("cell_value", want.cell_value, out_data.cell_value);
          field_check("z_index", want.z_index, out_data.z_index);
          field_check("pos_i", want.pos_i, out_data.pos_i);
          field_check("pos_j", want.pos_j, out_data.pos_j);
          field_check("pos_k", want.pos_k, out_data.pos_k);
          field_check("status", want.status, out_data.status);
        end
        case (out_data.status)
          ST_DONE:    n_done++;
          ST_BLOCKED: n_blocked++;
          ST_RANGE:   n_range++;
          default: ;
        endcase
      end
    end
  end

  // Watchdog on cycles without any transaction
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      quiet = 0;
    else
      quiet++;
    if (quiet >= QUIET_MAX) begin
      $display("%0t: no transaction for %0d cycles, %0d reports outstanding",
               $time, QUIET_MAX, cursor_reports.size());
      $display("morton_order_cube_walker_core regression: fail");
      $finish;
    end
  end

  // Stimulus sequence
  initial begin
    int side_plan [8];
    int start;
    side_plan = '{0, 31, 1, 17, 2, 16, 9, 0};
    side_plan[7] = $urandom_range(3, 15);
    repeat (2) @(negedge clk);
    rst <= 1'b0;

    // full cube: edges, write to the cursor cell, blocked moves at both corners
    queue_item(ACT_WRITE, 4'd0, 4'd0, 4'd0, 32'h7FFF_FFFF);
    queue_item(ACT_K_DOWN, 4'd0, 4'd0, 4'd0, '0);
    queue_item(ACT_J_DOWN, 4'd0, 4'd0, 4'd0, '0);
    queue_item(ACT_I_DOWN, 4'd0, 4'd0, 4'd0, '0);
    queue_item(ACT_TELEPORT, 4'd0, 4'd0, 4'd0, '0);
    queue_item(ACT_WRITE, 4'd0, 4'd0, 4'd0, 32'h8000_0000);
    queue_item(ACT_K_UP, 4'd0, 4'd0, 4'd0, '0);
    queue_item(ACT_J_UP, 4'd0, 4'd0, 4'd0, '0);
    queue_item(ACT_WRITE, 4'd15, 4'd15, 4'd15, 32'hFFFF_FFFF);
    queue_item(ACT_TELEPORT, 4'd15, 4'd15, 4'd15, '0);
    queue_item(ACT_I_UP, 4'd0, 4'd0, 4'd0, '0);
    queue_item(ACT_J_UP, 4'd0, 4'd0, 4'd0, '0);
    queue_item(ACT_K_UP, 4'd0, 4'd0, 4'd0, '0);
    queue_item(ACT_I_DOWN, 4'd0, 4'd0, 4'd0, '0);
    queue_item(ACT_J_DOWN, 4'd0, 4'd0, 4'd0, '0);
    queue_item(ACT_K_DOWN, 4'd0, 4'd0, 4'd0, '0);
    drain();

    // shrink the cube under the cursor, then teleports past the edge
    set_side(5'd4);
    queue_item(ACT_I_UP, 4'd0, 4'd0, 4'd0, '0);
    queue_item(ACT_I_DOWN, 4'd0, 4'd0, 4'd0, '0);
    queue_item(ACT_TELEPORT, 4'd4, 4'd0, 4'd0, '0);
    queue_item(ACT_TELEPORT, 4'd0, 4'd4, 4'd0, '0);
    queue_item(ACT_TELEPORT, 4'd0, 4'd0, 4'd4, '0);
    queue_item(ACT_TELEPORT, 4'd3, 4'd3, 4'd3, '0);
    queue_item(ACT_K_UP, 4'd0, 4'd0, 4'd0, '0);
    queue_item(ACT_WRITE, 4'd15, 4'd15, 4'd15, 32'h0);
    drain();

    // random walks under a range of side lengths
    foreach (side_plan[p]) begin
      set_side(SideBits'(side_plan[p]));
      start = action_queue.size();
      while (action_queue.size() - start < WALK_ITEMS) random_item();
      drain();
    end

    repeat (4) @(posedge clk);
    $display("covered %0d transactions under %0d side-length writes, %0d reports checked",
             actions_sent, side_writes, reports_seen);
    $display("status mix: %0d done, %0d blocked at edge, %0d teleports out of range",
             n_done, n_blocked, n_range);
    if (errors == 0 && cursor_reports.size() == 0) begin
      $display("morton_order_cube_walker_core regression: pass");
    end else begin
      $display("%0d mismatches, %0d reports never arrived", errors, cursor_reports.size());
      $display("morton_order_cube_walker_core regression: fail");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/mcw_pkg.sv
rtl/mcw_step.sv
rtl/morton_order_cube_walker_core.sv
bench/testbench.sv
